@@ rtl/fdd_pkg.sv @@
`timescale 1ns / 1ps
// fdd_pkg.sv: shared constants, codes and controller/datapath interface types.
package fdd_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int WIN_DEPTH    = 8;
    localparam int TAP_SPAN     = 5;
    localparam int TAP_COUNT    = 2 * TAP_SPAN + 1;
    localparam int EXT_SLOTS    = 16;
    localparam int SH_W         = $clog2(EXT_SLOTS * SAMPLE_WIDTH);
    // The largest stencil has coefficient magnitudes summing to 640, below 2^10.
    localparam int NUM_W        = SAMPLE_WIDTH + 10;
    localparam int INV_W        = 16;
    localparam int OUT_W        = 32;
    localparam int P1_W         = NUM_W + INV_W;
    localparam int P2_W         = P1_W + INV_W;

    // Scaling: first derivatives divide by 512 or 256, the second by 12 * 65536,
    // taken as a shift by 2^18 followed by an exact division by three.
    localparam int SHIFT_CENTRAL = 9;
    localparam int SHIFT_FORWARD = 8;
    localparam int SHIFT_SECOND  = 18;
    localparam int Z_W           = P2_W - SHIFT_SECOND;
    localparam int DIG_W         = 16;
    localparam int DIV_STEPS     = Z_W / DIG_W + 1;
    localparam int Q_W           = DIV_STEPS * DIG_W;
    localparam int DCNT_W        = $clog2(DIV_STEPS);
    localparam int DV_W          = DIG_W + 2;
    localparam int RECIP3_SHIFT  = DIG_W + 3;
    localparam logic [DV_W-1:0] RECIP3 = DV_W'((2 ** RECIP3_SHIFT + 2) / 3);

    localparam logic [Q_W-1:0]   NEG_LIMIT = Q_W'(64'h0000_0000_8000_0000);
    localparam logic [Q_W-1:0]   POS_LIMIT = Q_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [OUT_W-1:0] OUT_MIN   = 32'h8000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX   = 32'h7FFF_FFFF;

    // Counters
    localparam int              CNT_W    = 3;
    localparam logic [CNT_W-1:0] SEEN_MAX = 3'd7;

    // Modes
    localparam logic [1:0] MODE_CENTRAL = 2'd0;
    localparam logic [1:0] MODE_FORWARD = 2'd1;
    localparam logic [1:0] MODE_SECOND  = 2'd2;
    localparam logic [1:0] MODE_ALIAS   = 2'd3;

    localparam logic [CNT_W-1:0] LOOK_CENTRAL = 3'd2;
    localparam logic [CNT_W-1:0] LOOK_FORWARD = 3'd1;
    localparam logic [CNT_W-1:0] LOOK_SECOND  = 3'd5;
    localparam logic [CNT_W-1:0] MIN_CENTRAL  = 3'd3;
    localparam logic [CNT_W-1:0] MIN_FORWARD  = 3'd2;
    localparam logic [CNT_W-1:0] MIN_SECOND   = 3'd7;

    // Configuration register indexes
    localparam logic       REG_MODE  = 1'b0;
    localparam logic       REG_INV   = 1'b1;
    localparam logic [INV_W-1:0] INV_RESET = 16'd256;

    // Stencil kinds
    localparam int KIND_W = 4;
    localparam logic [KIND_W-1:0] KIND_ZERO  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_C_FWD = 4'd1;
    localparam logic [KIND_W-1:0] KIND_C_BWD = 4'd2;
    localparam logic [KIND_W-1:0] KIND_C_CEN = 4'd3;
    localparam logic [KIND_W-1:0] KIND_F_FWD = 4'd4;
    localparam logic [KIND_W-1:0] KIND_F_BWD = 4'd5;
    localparam logic [KIND_W-1:0] KIND_S_FWD = 4'd6;
    localparam logic [KIND_W-1:0] KIND_S_BWD = 4'd7;
    localparam logic [KIND_W-1:0] KIND_S_CEN = 4'd8;

    // Datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL1  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL2  = 3'd3;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [OP_W-1:0]   op;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  d;
        logic              eor;
        logic              too_short;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       out_free;
    } dp_status_t;

endpackage

@@ rtl/fdd_ctrl.sv @@
`timescale 1ns / 1ps
// fdd_ctrl.sv: sequencing state machine, stream counters and stencil choice.
module fdd_ctrl
    import fdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       is_last,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NUM   = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic              last_reg, last_next;
    logic              short_reg, short_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic [CNT_W-1:0]  look;
    logic [CNT_W-1:0]  min_len;
    logic [CNT_W-1:0]  seen_inc;
    logic              known, at0, at1, end0, end1;
    logic [KIND_W-1:0] kind;

    always_comb
    begin
        look    = LOOK_SECOND;
        min_len = MIN_SECOND;
        case (status.mode)
            MODE_CENTRAL:
            begin
                look    = LOOK_CENTRAL;
                min_len = MIN_CENTRAL;
            end
            MODE_FORWARD:
            begin
                look    = LOOK_FORWARD;
                min_len = MIN_FORWARD;
            end
            default:
            begin
                look    = LOOK_SECOND;
                min_len = MIN_SECOND;
            end
        endcase
    end

    assign seen_inc = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 3'd1;

    // Stencil choice for the sample d places behind the newest one.
    always_comb
    begin
        known = (seen_reg != SEEN_MAX);
        at0   = known && (seen_reg == d_reg);
        at1   = known && (seen_reg == d_reg + 3'd1);
        end0  = last_reg && (d_reg == 3'd0);
        end1  = last_reg && (d_reg == 3'd1);
        if (short_reg)
        begin
            kind = KIND_ZERO;
        end
        else
        begin
            case (status.mode)
                MODE_CENTRAL:
                    kind = at0 ? KIND_C_FWD : (end0 ? KIND_C_BWD : KIND_C_CEN);
                MODE_FORWARD:
                    kind = end0 ? KIND_F_BWD : KIND_F_FWD;
                default:
                    kind = (at0 || at1) ? KIND_S_FWD
                         : ((end0 || end1) ? KIND_S_BWD : KIND_S_CEN);
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        pending_next  = pending_reg;
        d_next        = d_reg;
        last_next     = last_reg;
        short_next    = short_reg;
        dcnt_next     = dcnt_reg;
        cmd.shift     = 1'b0;
        cmd.clear     = 1'b0;
        cmd.op        = OP_NONE;
        cmd.kind      = kind;
        cmd.d         = d_reg;
        cmd.eor       = last_reg && (d_reg == 3'd0);
        cmd.too_short = short_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.shift = 1'b1;
                    if (is_last)
                    begin
                        last_next  = 1'b1;
                        state_next = S_NUM;
                        if (({1'b0, seen_reg} + 4'd1) < {1'b0, min_len})
                        begin
                            short_next = 1'b1;
                            d_next     = 3'd0;
                        end
                        else
                        begin
                            short_next = 1'b0;
                            d_next     = pending_reg;
                        end
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        short_next = 1'b0;
                        if (({1'b0, pending_reg} + 4'd1) > {1'b0, look})
                        begin
                            d_next       = look;
                            pending_next = look;
                            state_next   = S_NUM;
                        end
                        else
                        begin
                            pending_next = pending_reg + 3'd1;
                            seen_next    = seen_inc;
                        end
                    end
                end
            end
            S_NUM:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = (status.mode == MODE_SECOND) ? S_MUL2 : S_SCALE;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                dcnt_next  = DCNT_W'(DIV_STEPS - 1);
                state_next = (status.mode == MODE_SECOND) ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (dcnt_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (last_reg && (d_reg != 3'd0))
                    begin
                        d_next     = d_reg - 3'd1;
                        state_next = S_NUM;
                    end
                    else if (last_reg)
                    begin
                        cmd.clear    = 1'b1;
                        seen_next    = '0;
                        pending_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        seen_next  = seen_inc;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            seen_reg    <= '0;
            pending_reg <= '0;
            d_reg       <= '0;
            last_reg    <= 1'b0;
            short_reg   <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seen_reg    <= seen_next;
            pending_reg <= pending_next;
            d_reg       <= d_next;
            last_reg    <= last_next;
            short_reg   <= short_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    // Pending results never exceed the longest lookahead.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= LOOK_SECOND)
        else $error("pending count beyond the longest lookahead");

    // A result is only pushed into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> status.out_free)
        else $error("result emitted while the output register is full");

    // A closing word always starts at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && is_last) |=> (state_reg == S_NUM))
        else $error("closing word did not start a flush");

    // The final result of a stream leaves the counters cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && status.out_free && last_reg && d_reg == 3'd0)
        |=> (seen_reg == '0 && pending_reg == '0 && state_reg == S_IDLE))
        else $error("counters not cleared at end of stream");

endmodule

@@ rtl/fdd_datapath.sv @@
`timescale 1ns / 1ps
// fdd_datapath.sv: sample window, stencil sum, scaling multiplies, divide by three, output register.
module fdd_datapath
    import fdd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [INV_W-1:0]               cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [OUT_W-1:0]        derivative,
    output logic                           end_of_run,
    output logic                           too_short
);

    localparam int EXT_W = EXT_SLOTS * SAMPLE_WIDTH;
    localparam int WIN_W = WIN_DEPTH * SAMPLE_WIDTH;

    logic [WIN_W-1:0]       win_reg, win_next;
    logic [1:0]             mode_reg, mode_next;
    logic [INV_W-1:0]       inv_reg, inv_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   neg_reg, neg_next;
    logic [NUM_W-1:0]       mag_reg, mag_next;
    logic [P2_W-1:0]        p_reg, p_next;
    logic [Q_W-1:0]         qz_reg, qz_next;
    logic [1:0]             rem_reg, rem_next;
    logic [OUT_W-1:0]       deriv_reg, deriv_next;
    logic                   eor_reg, eor_next;
    logic                   short_reg, short_next;

    logic [EXT_W-1:0]       ext;
    logic [EXT_W-1:0]       view;
    logic [SH_W-1:0]        shamt;
    logic signed [NUM_W-1:0] t [0:TAP_COUNT-1];
    logic signed [NUM_W-1:0] num;

    logic [DV_W-1:0]        dv;
    logic [2*DV_W-1:0]      dprod;
    logic [DIG_W-1:0]       qd;
    logic [DV_W-1:0]        tri_qd;
    logic [Q_W-1:0]         neg_mag;
    logic [OUT_W-1:0]       sat;

    // Window slot s of ext holds the sample s - TAP_SPAN places behind the newest,
    // zero outside the window; shifting by d centres the taps on that sample.
    assign ext   = {{((EXT_SLOTS - WIN_DEPTH - TAP_SPAN) * SAMPLE_WIDTH){1'b0}},
                    win_reg, {(TAP_SPAN * SAMPLE_WIDTH){1'b0}}};
    assign shamt = SH_W'(cmd.d) * SH_W'(SAMPLE_WIDTH);
    assign view  = ext >> shamt;

    always_comb
    begin
        for (int kk = 0; kk < TAP_COUNT; kk++)
        begin
            t[kk] = NUM_W'($signed(view[kk*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
        end
    end

    // t[5] is the sample itself, t[4] the next newer one, t[6] the next older one.
    always_comb
    begin
        case (cmd.kind)
            KIND_C_FWD: num = NUM_W'(t[4] * 4 - t[5] * 3 - t[3]);
            KIND_C_BWD: num = NUM_W'(t[5] * 3 - t[6] * 4 + t[7]);
            KIND_C_CEN: num = NUM_W'(t[4] - t[6]);
            KIND_F_FWD: num = NUM_W'(t[4] - t[5]);
            KIND_F_BWD: num = NUM_W'(t[5] - t[6]);
            KIND_S_FWD: num = NUM_W'(t[5] * 45 - t[4] * 154 + t[3] * 214
                                   - t[2] * 156 + t[1] * 61 - t[0] * 10);
            KIND_S_BWD: num = NUM_W'(t[5] * 45 - t[6] * 154 + t[7] * 214
                                   - t[8] * 156 + t[9] * 61 - t[10] * 10);
            KIND_S_CEN: num = NUM_W'(t[4] * 16 + t[6] * 16 - t[5] * 30
                                   - t[3] - t[7]);
            default:    num = '0;
        endcase
    end

    // One quotient digit of the division by three per step.
    always_comb
    begin
        dv     = {rem_reg, qz_reg[Q_W-1 -: DIG_W]};
        dprod  = (2*DV_W)'(dv) * (2*DV_W)'(RECIP3);
        qd     = dprod[RECIP3_SHIFT +: DIG_W];
        tri_qd = (DV_W'(qd) << 1) + DV_W'(qd);
    end

    // Truncated magnitude back to a saturated signed value.
    always_comb
    begin
        neg_mag = Q_W'(0) - qz_reg;
        if (neg_reg)
        begin
            sat = (qz_reg > NEG_LIMIT) ? OUT_MIN : neg_mag[OUT_W-1:0];
        end
        else
        begin
            sat = (qz_reg > POS_LIMIT) ? OUT_MAX : qz_reg[OUT_W-1:0];
        end
    end

    always_comb
    begin
        win_next       = win_reg;
        mode_next      = mode_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        p_next         = p_reg;
        qz_next        = qz_reg;
        rem_next       = rem_reg;
        deriv_next     = deriv_reg;
        eor_next       = eor_reg;
        short_next     = short_reg;

        if (cfg_write)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_next = (cfg_data[1:0] == MODE_ALIAS) ? MODE_SECOND : cfg_data[1:0];
            end
            else
            begin
                inv_next = cfg_data;
            end
        end

        if (cmd.shift)
        begin
            win_next = {win_reg[WIN_W-SAMPLE_WIDTH-1:0], sample};
        end
        else if (cmd.clear)
        begin
            win_next = '0;
        end

        case (cmd.op)
            OP_LOAD:
            begin
                neg_next = num[NUM_W-1];
                mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            end
            OP_MUL1:
            begin
                p_next = P2_W'(P1_W'(mag_reg) * P1_W'(inv_reg));
            end
            OP_MUL2:
            begin
                p_next = P2_W'(p_reg[P1_W-1:0]) * P2_W'(inv_reg);
            end
            OP_SCALE:
            begin
                rem_next = 2'd0;
                case (mode_reg)
                    MODE_CENTRAL: qz_next = Q_W'(p_reg[P1_W-1:SHIFT_CENTRAL]);
                    MODE_FORWARD: qz_next = Q_W'(p_reg[P1_W-1:SHIFT_FORWARD]);
                    default:      qz_next = Q_W'(p_reg[P2_W-1:SHIFT_SECOND]);
                endcase
            end
            OP_DIV:
            begin
                qz_next  = {qz_reg[Q_W-DIG_W-1:0], qd};
                rem_next = dv[1:0] - tri_qd[1:0];
            end
            OP_EMIT:
            begin
                deriv_next     = sat;
                eor_next       = cmd.eor;
                short_next     = cmd.too_short;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            mode_reg      <= MODE_CENTRAL;
            inv_reg       <= INV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            mode_reg      <= mode_next;
            inv_reg       <= inv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        p_reg     <= p_next;
        qz_reg    <= qz_next;
        rem_reg   <= rem_next;
        deriv_reg <= deriv_next;
        eor_reg   <= eor_next;
        short_reg <= short_next;
    end

    assign status.mode     = mode_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign derivative = $signed(deriv_reg);
    assign end_of_run = eor_reg;
    assign too_short  = short_reg;

endmodule

@@ rtl/finite_difference_derivative.sv @@
`timescale 1ns / 1ps
// finite_difference_derivative.sv: top level of the streaming derivative block.
// A result passes through the numerator, the multiply and the scaling into the output
// register in modes 0 and 1; mode 2 adds a second multiply and three divide steps.
// A word that causes no result leaves the controller idle for the next word; one that
// causes a result holds off further words until the shared multiply and divide sequence
// has pushed it into the output register. The closing word flushes up to six results in turn.
// Reset (rst_n, asynchronous, active low) clears the window and counters, sets mode 0, inv_step 256.

// The block is split into a controller and a datapath. The controller owns the stream
// counters (samples seen, saturating at seven, and results still owed) and decides, for
// each accepted word, whether a result falls due and with which stencil. The datapath
// holds the eight-sample window, forms the stencil numerator, scales it by inv_step
// (once for first derivatives, twice for the second), divides exactly by three where
// the second derivative needs it, and saturates into the output register.
//
// Input words are taken only while the controller is idle. The output register is
// separate from the arithmetic, so a finished result can wait on out_ready while the
// controller goes back to idle and takes the next word.
module finite_difference_derivative
    import fdd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [INV_W-1:0]               cfg_data,
    // input words
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           is_last,
    // result words
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [OUT_W-1:0]        derivative,
    output logic                           end_of_run,
    output logic                           too_short
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing: window shift on acceptance, then numerator, multiplies, scaling,
    // optional division and finally the push into the output register.
    fdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, configuration registers and the output register.
    fdd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .derivative (derivative),
        .end_of_run (end_of_run),
        .too_short  (too_short)
    );

endmodule

@@ test/derivative_checker.sv @@
`timescale 1ns / 1ps
// Checker for the derivative block: follows its registers, predicts each result word and compares.
module derivative_checker
    import fdd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [INV_W-1:0]               cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           is_last,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [OUT_W-1:0]        derivative,
    input  logic                           end_of_run,
    input  logic                           too_short,
    output int                             owed_count,
    output int                             fail_count
);

    typedef struct packed {
        logic signed [OUT_W-1:0] derivative;
        logic                    end_of_run;
        logic                    too_short;
    } derivative_word_t;

    longint           recent_samples [WIN_DEPTH];   // newest first
    int               samples_seen;
    int               results_due;
    logic [1:0]       cur_mode;
    logic [INV_W-1:0] cur_inv;
    derivative_word_t owed_words [$];
    int               fails;

    function automatic int lookahead_of(logic [1:0] m);
        case (m)
            MODE_CENTRAL: return int'(LOOK_CENTRAL);
            MODE_FORWARD: return int'(LOOK_FORWARD);
            default:      return int'(LOOK_SECOND);
        endcase
    endfunction

    function automatic int shortest_run(logic [1:0] m);
        case (m)
            MODE_CENTRAL: return int'(MIN_CENTRAL);
            MODE_FORWARD: return int'(MIN_FORWARD);
            default:      return int'(MIN_SECOND);
        endcase
    endfunction

    // trunc(num * mul / den), saturated to 32 bits.
    function automatic longint scaled_sat(longint num, longint unsigned mul,
                                          longint unsigned den);
        logic            neg;
        longint unsigned mag;
        longint unsigned q;
        neg = num < 0;
        mag = neg ? $unsigned(-num) : $unsigned(num);
        q = (mag / den) * mul + ((mag % den) * mul) / den;
        if (neg)
        begin
            if (q > 64'd2147483648)
                q = 64'd2147483648;
            return -$signed(q);
        end
        if (q > 64'd2147483647)
            q = 64'd2147483647;
        return $signed(q);
    endfunction

    // Sample r places later than the one held at window offset d; zero outside the window.
    function automatic longint tap(int d, int r);
        int idx;
        idx = d - r;
        if (idx < 0 || idx >= WIN_DEPTH)
            return 0;
        return recent_samples[idx];
    endfunction

    function automatic longint derivative_at(int d, logic last);
        logic            known;
        logic            at0;
        logic            at1;
        logic            end0;
        logic            end1;
        int              s;
        longint          num;
        longint unsigned inv;
        known = samples_seen < SEEN_MAX;
        at0   = known && samples_seen == d;
        at1   = known && samples_seen == d + 1;
        end0  = last && d == 0;
        end1  = last && d == 1;
        inv   = cur_inv;
        if (cur_mode == MODE_CENTRAL)
        begin
            if (at0)
                num = -3 * tap(d, 0) + 4 * tap(d, 1) - tap(d, 2);
            else if (end0)
                num = 3 * tap(d, 0) - 4 * tap(d, -1) + tap(d, -2);
            else
                num = tap(d, 1) - tap(d, -1);
            return scaled_sat(num, inv, 512);
        end
        if (cur_mode == MODE_FORWARD)
        begin
            if (end0)
                num = tap(d, 0) - tap(d, -1);
            else
                num = tap(d, 1) - tap(d, 0);
            return scaled_sat(num, inv, 256);
        end
        if (at0 || at1 || end0 || end1)
        begin
            s = (at0 || at1) ? 1 : -1;
            num = 45 * tap(d, 0) - 154 * tap(d, s) + 214 * tap(d, 2 * s)
                - 156 * tap(d, 3 * s) + 61 * tap(d, 4 * s) - 10 * tap(d, 5 * s);
        end
        else
        begin
            num = -tap(d, -2) + 16 * tap(d, -1) - 30 * tap(d, 0)
                + 16 * tap(d, 1) - tap(d, 2);
        end
        return scaled_sat(num, inv * inv, 12 * 65536);
    endfunction

    task automatic owe(longint value, logic eor, logic short_run);
        derivative_word_t w;
        w.derivative = value[OUT_W-1:0];
        w.end_of_run = eor;
        w.too_short  = short_run;
        owed_words.push_back(w);
    endtask

    task automatic take_sample(logic signed [SAMPLE_WIDTH-1:0] value, logic last);
        int i;
        int look;
        int d;
        look = lookahead_of(cur_mode);
        for (i = WIN_DEPTH - 1; i > 0; i--)
            recent_samples[i] = recent_samples[i - 1];
        recent_samples[0] = value;
        if (!last)
        begin
            if (results_due + 1 > look)
            begin
                owe(derivative_at(look, 1'b0), 1'b0, 1'b0);
                results_due = look;
            end
            else
                results_due++;
            if (samples_seen < SEEN_MAX)
                samples_seen++;
            return;
        end
        if (samples_seen + 1 < shortest_run(cur_mode))
            owe(0, 1'b1, 1'b1);
        else
        begin
            for (d = results_due; d >= 0; d--)
                owe(derivative_at(d, 1'b1), d == 0, 1'b0);
        end
        for (i = 0; i < WIN_DEPTH; i++)
            recent_samples[i] = 0;
        samples_seen = 0;
        results_due  = 0;
    endtask

    task automatic check_word();
        derivative_word_t want;
        if (owed_words.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("%0t: result word with none expected: %0d eor %0b short %0b",
                         $time, derivative, end_of_run, too_short);
            return;
        end
        want = owed_words.pop_front();
        if (derivative !== want.derivative || end_of_run !== want.end_of_run
            || too_short !== want.too_short)
        begin
            fails++;
            if (fails <= 10)
                $display("%0t: mismatch: got %0d eor %0b short %0b, wanted %0d eor %0b short %0b",
                         $time, derivative, end_of_run, too_short,
                         $signed(want.derivative), want.end_of_run, want.too_short);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                recent_samples[i] = 0;
            samples_seen = 0;
            results_due  = 0;
            cur_mode     = MODE_CENTRAL;
            cur_inv      = INV_RESET;
            owed_words.delete();
            fails        = 0;
            owed_count  <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_MODE)
                    cur_mode = (cfg_data[1:0] == MODE_ALIAS) ? MODE_SECOND : cfg_data[1:0];
                else
                    cur_inv = cfg_data;
            end
            if (in_valid && in_ready)
                take_sample(sample, is_last);
            if (out_valid && out_ready)
                check_word();
            owed_count <= owed_words.size();
            fail_count <= fails;
        end
    end

endmodule

@@ test/finite_difference_derivative_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the derivative block: stimulus, flow control and the final verdict.
module finite_difference_derivative_test
    import fdd_pkg::*;
();

    localparam int CYCLE_LIMIT     = 1000000;
    // A word that brings no result may still be in flight when the last owed word has come;
    // this is comfortably more than the longest second-derivative sequence.
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 40;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_write = 1'b0;
    logic                           cfg_index = REG_MODE;
    logic [INV_W-1:0]               cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic signed [SAMPLE_WIDTH-1:0] sample    = '0;
    logic                           is_last   = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [OUT_W-1:0]        derivative;
    logic                           end_of_run;
    logic                           too_short;

    int owed_count;
    int fail_count;
    int gap_pct     = 0;   // chance, in percent, of an idle burst before an input word
    int stall_pct   = 0;   // chance, in percent, per cycle of starting a receiver stall
    int stall_left  = 0;
    int cycles_run  = 0;
    int phase_words = 0;

    finite_difference_derivative dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .derivative (derivative),
        .end_of_run (end_of_run),
        .too_short  (too_short)
    );

    derivative_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .derivative (derivative),
        .end_of_run (end_of_run),
        .too_short  (too_short),
        .owed_count (owed_count),
        .fail_count (fail_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls in bursts. A burst that has started always runs
    // to its end, so a change of stall_pct never cuts one short.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(19, 1);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: the slowest correct run is far below this limit.
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("simulation failed");
        $finish;
    end

    // Present one input word, possibly after an idle burst, and hold it until it is taken.
    // Valid is only lowered when a burst is chosen, so back-to-back words keep it high.
    task automatic offer_word(logic signed [SAMPLE_WIDTH-1:0] value, logic last);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every owed result word has arrived and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the strobe drops on the next edge so that writes never collide.
    task automatic write_reg(logic idx, logic [INV_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int shortest_run(logic [1:0] m);
        case (m)
            MODE_CENTRAL: return int'(MIN_CENTRAL);
            MODE_FORWARD: return int'(MIN_FORWARD);
            default:      return int'(MIN_SECOND);
        endcase
    endfunction

    // Samples lean on the extremes and on small values, with plenty of full-range noise.
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3, 4, 5: return SAMPLE_WIDTH'($signed($urandom_range(600)) - 300);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // One stream closed by its last word. Most streams are long enough for the stencil of
    // the mode; one in five is deliberately short. Now and then the mode is changed part
    // way through the stream, and put back once the stream has closed.
    task automatic run_stream(logic [1:0] base_mode);
        int len;
        int switch_at;
        int k;
        if ($urandom_range(4) == 0)
            len = $urandom_range(shortest_run(base_mode) - 1, 1);
        else
            len = $urandom_range(16, shortest_run(base_mode));
        switch_at = 0;
        if (len > 1 && $urandom_range(7) == 0)
            switch_at = $urandom_range(len - 1, 1);
        for (k = 0; k < len; k++)
        begin
            if (switch_at != 0 && k == switch_at)
            begin
                settle();
                write_reg(REG_MODE, INV_W'($urandom_range(3)));
            end
            offer_word(pick_sample(), k == len - 1);
            phase_words++;
        end
        if (switch_at != 0)
        begin
            settle();
            write_reg(REG_MODE, INV_W'(base_mode));
        end
    endtask

    initial
    begin
        int               k;
        int               phase;
        logic [1:0]       phase_mode;
        logic [INV_W-1:0] phase_inv;

        gap_pct = 30;
        stall_pct <= 30;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings, central difference with unit step: full-scale swings exercise
        // both one-sided end stencils.
        offer_word(SAMPLE_MAX, 1'b0);
        offer_word(SAMPLE_MIN, 1'b0);
        offer_word(SAMPLE_MAX, 1'b1);
        // Two words are one short of the central stencil.
        offer_word(16'sd100, 1'b0);
        offer_word(-16'sd100, 1'b1);

        // Forward difference at the largest inverse step, then a single-word stream.
        settle();
        write_reg(REG_MODE, INV_W'(MODE_FORWARD));
        write_reg(REG_INV, '1);
        offer_word(SAMPLE_MIN, 1'b0);
        offer_word(SAMPLE_MAX, 1'b0);
        offer_word(SAMPLE_MIN, 1'b1);
        offer_word(16'sd5, 1'b1);

        // Second derivative on alternating extremes at the largest step saturates both ways.
        settle();
        write_reg(REG_MODE, INV_W'(MODE_SECOND));
        for (k = 0; k < 7; k++)
            offer_word(k[0] ? SAMPLE_MIN : SAMPLE_MAX, k == 6);

        // The spare mode code behaves as the second derivative: one word is too short.
        settle();
        write_reg(REG_MODE, INV_W'(MODE_ALIAS));
        write_reg(REG_INV, '0);
        offer_word(-16'sd1, 1'b1);

        // A zero inverse step flattens every result to zero.
        settle();
        write_reg(REG_MODE, INV_W'(MODE_FORWARD));
        offer_word(16'sd1234, 1'b0);
        offer_word(-16'sd4321, 1'b1);

        // Mode changed in the middle of a stream: the new lookahead applies at once.
        settle();
        write_reg(REG_MODE, INV_W'(MODE_CENTRAL));
        write_reg(REG_INV, 16'd300);
        offer_word(16'sd700, 1'b0);
        offer_word(-16'sd50, 1'b0);
        offer_word(16'sd9000, 1'b0);
        settle();
        write_reg(REG_MODE, INV_W'(MODE_FORWARD));
        offer_word(SAMPLE_MIN, 1'b0);
        offer_word(16'sd17, 1'b1);

        // Random phases, each with its own settings and its own amount of idling. The
        // second derivative mostly runs with small steps so that results do not all
        // saturate. The closing phase runs with no idling on either side.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    phase_mode = MODE_CENTRAL; phase_inv = '1;
                    gap_pct = 20; stall_pct <= 25;
                end
                1:
                begin
                    phase_mode = MODE_FORWARD; phase_inv = 16'd1;
                    gap_pct = 0; stall_pct <= 40;
                end
                2:
                begin
                    phase_mode = MODE_SECOND; phase_inv = INV_W'($urandom_range(300, 1));
                    gap_pct = 35; stall_pct <= 0;
                end
                3:
                begin
                    phase_mode = MODE_ALIAS; phase_inv = INV_W'($urandom_range(120, 1));
                    gap_pct = 10; stall_pct <= 10;
                end
                4:
                begin
                    phase_mode = MODE_CENTRAL; phase_inv = INV_W'($urandom);
                    gap_pct = 50; stall_pct <= 50;
                end
                5:
                begin
                    phase_mode = MODE_FORWARD; phase_inv = INV_W'($urandom);
                    gap_pct = 15; stall_pct <= 20;
                end
                6:
                begin
                    phase_mode = MODE_SECOND; phase_inv = '1;
                    gap_pct = 25; stall_pct <= 15;
                end
                default:
                begin
                    phase_mode = MODE_SECOND; phase_inv = INV_W'($urandom_range(700, 1));
                    gap_pct = 0; stall_pct <= 0;
                end
            endcase
            settle();
            write_reg(REG_MODE, INV_W'(phase_mode));
            write_reg(REG_INV, phase_inv);
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
                run_stream(phase_mode);
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ finite_difference_derivative.f @@
rtl/fdd_pkg.sv
rtl/fdd_ctrl.sv
rtl/fdd_datapath.sv
rtl/finite_difference_derivative.sv
test/derivative_checker.sv
test/finite_difference_derivative_test.sv
